/* sv/rgbgd_pkg.sv */
`timescale 1ns / 1ps

package rgbgd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CfgDirection     = 2'd0;
    localparam logic [1:0] CfgBytesPerPixel = 2'd1;

    // Direction codes
    localparam logic DirForward = 1'b0;
    localparam logic DirInverse = 1'b1;

    // Pixel size that adds the alpha channel
    localparam logic [2:0] SizeWithAlpha = 3'd4;

    // Byte positions within a pixel
    localparam logic [1:0] PosFirst = 2'd0;
    localparam logic [1:0] PosSecond = 2'd1;
    localparam logic [1:0] PosThird = 2'd2;
    localparam logic [1:0] PosAlpha = 2'd3;

    // One finished pixel: its transformed bytes in output order
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic            alpha;
    } t_pixel;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

/* sv/rgbgd_front.sv */
`timescale 1ns / 1ps

module rgbgd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [2:0]          i_cfg_data,
    input  rgbgd_pkg::t_fifo_stat i_stat,
    output logic                o_push,
    output rgbgd_pkg::t_pixel   o_pixel
);

    logic       r_direction;
    logic [2:0] r_bytes_per_pixel;
    logic [1:0] r_pos;
    logic [7:0] r_prev_alpha;
    logic [7:0] r_store [3];

    logic       size4;
    logic       complete;
    logic       accept;
    logic [7:0] p0, p1, p2;
    logic [7:0] n_prev_alpha;
    logic [7:0] alpha_out;

    // Pixel size and completion test
    assign size4    = (r_bytes_per_pixel == rgbgd_pkg::SizeWithAlpha);
    assign complete = size4 ? (r_pos == rgbgd_pkg::PosAlpha) : (r_pos >= rgbgd_pkg::PosThird);

    // Bytes that do not complete a pixel never need queue space
    assign o_in_ready = !i_stat.full || !complete;
    assign accept     = i_in_valid && o_in_ready;

    // Current pixel bytes, the arriving byte bypassed in
    assign p0 = r_store[0];
    assign p1 = r_store[1];
    assign p2 = (r_pos == rgbgd_pkg::PosThird) ? i_data_byte : r_store[2];

    // Alpha channel: difference forward, running sum inverse
    always_comb begin
        if (r_direction == rgbgd_pkg::DirForward) begin
            alpha_out    = i_data_byte - r_prev_alpha;
            n_prev_alpha = i_data_byte;
        end else begin
            alpha_out    = r_prev_alpha + i_data_byte;
            n_prev_alpha = alpha_out;
        end
    end

    // Transformed pixel
    always_comb begin
        o_pixel.alpha = size4;
        if (r_direction == rgbgd_pkg::DirForward) begin
            o_pixel.bytes[0] = p1;
            o_pixel.bytes[1] = p1 - p2;
            o_pixel.bytes[2] = p1 - p0;
        end else begin
            o_pixel.bytes[0] = p0 - p2;
            o_pixel.bytes[1] = p0;
            o_pixel.bytes[2] = p0 - p1;
        end
        o_pixel.bytes[3] = alpha_out;
    end

    assign o_push = accept && complete;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction       <= rgbgd_pkg::DirForward;
            r_bytes_per_pixel <= 3'd3;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rgbgd_pkg::CfgDirection:     r_direction       <= i_cfg_data[0];
                rgbgd_pkg::CfgBytesPerPixel: r_bytes_per_pixel <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Byte position and previous alpha
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= rgbgd_pkg::PosFirst;
            r_prev_alpha <= 8'd0;
        end else if (accept) begin
            if (complete) begin
                r_pos <= rgbgd_pkg::PosFirst;
                if (size4) begin
                    r_prev_alpha <= n_prev_alpha;
                end
            end else begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    // Pixel store; the alpha position is not kept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            unique case (r_pos)
                rgbgd_pkg::PosFirst:  r_store[0] <= i_data_byte;
                rgbgd_pkg::PosSecond: r_store[1] <= i_data_byte;
                rgbgd_pkg::PosThird:  r_store[2] <= i_data_byte;
                default: ;
            endcase
        end
    end

endmodule

/* sv/rgbgd_fifo.sv */
`timescale 1ns / 1ps

module rgbgd_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  rgbgd_pkg::t_pixel     i_pixel,
    input  logic                  i_pop,
    output rgbgd_pkg::t_pixel     o_pixel,
    output rgbgd_pkg::t_fifo_stat o_stat
);

    rgbgd_pkg::t_pixel r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign o_pixel      = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: ;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pixel;
        end
    end

endmodule

/* sv/rgbgd_back.sv */
`timescale 1ns / 1ps

module rgbgd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rgbgd_pkg::t_pixel     i_pixel,
    input  rgbgd_pkg::t_fifo_stat i_stat,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_pixel_end
);

    logic [1:0] r_idx;
    logic       last;
    logic       accept;

    // Serialise the head pixel one byte per item
    assign last        = i_pixel.alpha ? (r_idx == rgbgd_pkg::PosAlpha)
                                       : (r_idx == rgbgd_pkg::PosThird);
    assign o_out_valid = !i_stat.empty;
    assign o_out_byte  = i_pixel.bytes[r_idx];
    assign o_pixel_end = last;
    assign accept      = o_out_valid && i_out_ready;
    assign o_pop       = accept && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= rgbgd_pkg::PosFirst;
        end else if (accept) begin
            r_idx <= last ? rgbgd_pkg::PosFirst : r_idx + 2'd1;
        end
    end

endmodule

/* sv/rgb_green_difference_transform.sv */
`timescale 1ns / 1ps

// Green-difference colour transform on a byte stream.
// Input channel (i_in_valid / o_in_ready) takes one pixel byte per item;
// pixels are B,G,R(,A) forward or G,G-R,G-B(,dA) inverse.
// Output channel (o_out_valid / i_out_ready) gives one transformed byte
// per item, o_pixel_end high on the last byte of a pixel.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
// index 0 direction and index 1 bytes per pixel; write only while idle.
// A completed pixel is registered into the pixel queue as its last byte
// is accepted; its first output byte is valid once it is at the queue head.
// Throughput: one input and one output byte per cycle sustained while the
// receiver is ready; the output side serialises a pixel at one byte per
// cycle from a two-entry pixel queue; the front takes bytes as it drains.
// When the receiver stalls the queue fills; bytes that do not complete a
// pixel are still taken, a completing byte waits for queue space.
// Reset empties the queue, clears byte position and previous alpha, and
// sets forward mode with 3-byte pixels.
module rgb_green_difference_transform (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_pixel_end,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [2:0] i_cfg_data
);

    rgbgd_pkg::t_pixel     push_pixel;
    rgbgd_pkg::t_pixel     head_pixel;
    rgbgd_pkg::t_fifo_stat stat;
    logic                  push;
    logic                  pop;

    assign o_cfg_ready = 1'b1;

    // Front: gather bytes, transform on completion
    rgbgd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (stat),
        .o_push      (push),
        .o_pixel     (push_pixel)
    );

    // Pixel queue
    rgbgd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pixel (push_pixel),
        .i_pop   (pop),
        .o_pixel (head_pixel),
        .o_stat  (stat)
    );

    // Back: byte serialiser
    rgbgd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pixel     (head_pixel),
        .i_stat      (stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_pixel_end (o_pixel_end)
    );

endmodule
